>>> sv/lgcu_pkg.sv
// Shared types, constants and fixed-point helpers for the LSTM gate and cell update block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lgcu_pkg;

  // Data format: signed Q3.12 in 16 bits.
  localparam int DATA_W = 16;
  localparam int FRAC_W = 12;
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = DATA_W + 8;
  localparam int ACT_W  = DATA_W + 2;
  localparam int CLIP_W = DATA_W - 1;
  localparam int CFG_W  = CLIP_W;

  localparam int ONE_Q   = 1 << FRAC_W;
  localparam int SIG_T5  = 5 * ONE_Q;
  localparam int SIG_T2  = (19 * ONE_Q) >> 3;
  localparam int SIG_K27 = (27 * ONE_Q) >> 5;
  localparam int SIG_K5  = (5 * ONE_Q) >> 3;
  localparam int SIG_KH  = ONE_Q >> 1;
  localparam int DMAX    = (1 << (DATA_W - 1)) - 1;
  localparam int DMIN    = -(1 << (DATA_W - 1));

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CLIP_EN   = 3'd0,
    REG_CLIP_LVL  = 3'd1,
    REG_COUPLE    = 3'd2,
    REG_PEEP_EN   = 3'd3,
    REG_GATE_SEL  = 3'd4,
    REG_CAND_SEL  = 3'd5,
    REG_OUT_SEL   = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic              clip_en;
    logic [CLIP_W-1:0] clip_level;
    logic              couple;
    logic              peep_en;
    logic              gate_sel;
    logic              cand_sel;
    logic              out_sel;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] in_gate_pre;
    logic signed [DATA_W-1:0] out_gate_pre;
    logic signed [DATA_W-1:0] fgt_gate_pre;
    logic signed [DATA_W-1:0] cand_pre;
    logic signed [DATA_W-1:0] old_cell;
    logic signed [DATA_W-1:0] peep_in;
    logic signed [DATA_W-1:0] peep_out;
    logic signed [DATA_W-1:0] peep_fgt;
    logic                     last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_cell;
    logic signed [DATA_W-1:0] new_hidden;
    logic                     last_out;
  } out_item_t;

  // Saturate a wide sum to the data range.
  function automatic logic signed [DATA_W-1:0] sat_d(input logic signed [SUM_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > SUM_W'(DMAX)) begin
      r = DATA_W'(DMAX);
    end else if (x < SUM_W'(DMIN)) begin
      r = DATA_W'(DMIN);
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  // Round half up and drop the fraction bits of a full product.
  function automatic logic signed [SUM_W-1:0] qround(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] t;
    t = {p[PROD_W-1], p} + (PROD_W + 1)'(1 << (FRAC_W - 1));
    return SUM_W'(t >>> FRAC_W);
  endfunction

  // Clamp to plus or minus the clip level when clipping is on.
  function automatic logic signed [DATA_W-1:0] clipv(input logic en,
                                                     input logic [CLIP_W-1:0] lvl,
                                                     input logic signed [DATA_W-1:0] x);
    logic signed [DATA_W:0] c;
    logic signed [DATA_W:0] xe;
    logic signed [DATA_W-1:0] r;
    c  = $signed({2'b00, lvl});
    xe = (DATA_W + 1)'(x);
    r  = x;
    if (en) begin
      if (xe > c) begin
        r = c[DATA_W-1:0];
      end else if (xe < -c) begin
        r = DATA_W'(-c);
      end
    end
    return r;
  endfunction

  // Piecewise-linear sigmoid on a widened input.
  function automatic logic signed [ACT_W-1:0] sigm(input logic signed [ACT_W-1:0] x);
    logic [ACT_W-1:0] a;
    logic signed [ACT_W-1:0] y;
    a = x[ACT_W-1] ? ACT_W'(-x) : ACT_W'(x);
    if (a >= ACT_W'(SIG_T5)) begin
      y = ACT_W'(ONE_Q);
    end else if (a >= ACT_W'(SIG_T2)) begin
      y = $signed(a >> 5) + ACT_W'(SIG_K27);
    end else if (a >= ACT_W'(ONE_Q)) begin
      y = $signed(a >> 3) + ACT_W'(SIG_K5);
    end else begin
      y = $signed(a >> 2) + ACT_W'(SIG_KH);
    end
    if (x[ACT_W-1]) begin
      y = ACT_W'(ONE_Q) - y;
    end
    return y;
  endfunction

  // Activation: sigmoid when sel is 0, tanh as 2*sigmoid(2x)-1 when sel is 1.
  function automatic logic signed [DATA_W-1:0] act(input logic sel,
                                                   input logic signed [DATA_W-1:0] x);
    logic signed [ACT_W-1:0] xx;
    logic signed [ACT_W-1:0] s;
    logic signed [ACT_W-1:0] r;
    xx = sel ? ACT_W'($signed({x, 1'b0})) : ACT_W'(x);
    s  = sigm(xx);
    r  = sel ? ((s <<< 1) - ACT_W'(ONE_Q)) : s;
    return sat_d(SUM_W'(r));
  endfunction

endpackage

`default_nettype wire

>>> sv/lgcu_cfg.sv
// Configuration register file of the LSTM gate and cell update block.
// Depends on lgcu_pkg for the register index codes and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module lgcu_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [2:0]                 cfg_index,
  input  wire logic [lgcu_pkg::CFG_W-1:0] cfg_wdata,
  output lgcu_pkg::cfg_t                  cfg
);
  import lgcu_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode a write into the addressed register; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CLIP_EN:  cfg_nxt.clip_en    = cfg_wdata[0];
        REG_CLIP_LVL: cfg_nxt.clip_level = cfg_wdata[CLIP_W-1:0];
        REG_COUPLE:   cfg_nxt.couple     = cfg_wdata[0];
        REG_PEEP_EN:  cfg_nxt.peep_en    = cfg_wdata[0];
        REG_GATE_SEL: cfg_nxt.gate_sel   = cfg_wdata[0];
        REG_CAND_SEL: cfg_nxt.cand_sel   = cfg_wdata[0];
        REG_OUT_SEL:  cfg_nxt.out_sel    = cfg_wdata[0];
        default:      cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_en    <= 1'b0;
      cfg_r.clip_level <= '1;
      cfg_r.couple     <= 1'b0;
      cfg_r.peep_en    <= 1'b0;
      cfg_r.gate_sel   <= 1'b0;
      cfg_r.cand_sel   <= 1'b1;
      cfg_r.out_sel    <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> sv/lgcu_dp.sv
// Eight-stage datapath of the LSTM gate and cell update block, with per-stage
// valid bits and a stall chain. Depends on lgcu_pkg for types and arithmetic.
`timescale 1ns / 1ps
`default_nettype none

module lgcu_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  lgcu_pkg::cfg_t     cfg,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  lgcu_pkg::in_item_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output lgcu_pkg::out_item_t out_data
);
  import lgcu_pkg::*;

  localparam int NSTG = 8;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] rdy;

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt = v_r;
    if (rdy[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NSTG-1];

  // Stage 1: register the request and form the two old-cell peephole products.
  logic signed [DATA_W-1:0] s1_ip_r, s1_op_r, s1_fp_r, s1_cp_r, s1_oc_r, s1_po_r;
  logic signed [PROD_W-1:0] s1_mi_r, s1_mf_r;
  logic                     s1_last_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_ip_r   <= in_data.in_gate_pre;
      s1_op_r   <= in_data.out_gate_pre;
      s1_fp_r   <= in_data.fgt_gate_pre;
      s1_cp_r   <= in_data.cand_pre;
      s1_oc_r   <= in_data.old_cell;
      s1_po_r   <= in_data.peep_out;
      s1_mi_r   <= in_data.peep_in * in_data.old_cell;
      s1_mf_r   <= in_data.peep_fgt * in_data.old_cell;
      s1_last_r <= in_data.last_in;
    end
  end

  // Stage 2: peephole sums, clipping and the input, forget and candidate activations.
  logic signed [DATA_W-1:0] s2_ipk, s2_fpk;
  logic signed [DATA_W-1:0] s2_ig_r, s2_fg_r, s2_gg_r, s2_oc_r, s2_op_r, s2_po_r;
  logic                     s2_last_r;

  always_comb begin
    s2_ipk = cfg.peep_en ? sat_d(SUM_W'(s1_ip_r) + qround(s1_mi_r)) : s1_ip_r;
    s2_fpk = cfg.peep_en ? sat_d(SUM_W'(s1_fp_r) + qround(s1_mf_r)) : s1_fp_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_ig_r   <= act(cfg.gate_sel, clipv(cfg.clip_en, cfg.clip_level, s2_ipk));
      s2_fg_r   <= act(cfg.gate_sel, clipv(cfg.clip_en, cfg.clip_level, s2_fpk));
      s2_gg_r   <= act(cfg.cand_sel, clipv(cfg.clip_en, cfg.clip_level, s1_cp_r));
      s2_oc_r   <= s1_oc_r;
      s2_op_r   <= s1_op_r;
      s2_po_r   <= s1_po_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Stage 3: optional gate coupling, then the two cell products.
  logic signed [DATA_W-1:0] s3_fg;
  logic signed [PROD_W-1:0] s3_mf_r, s3_mi_r;
  logic signed [DATA_W-1:0] s3_op_r, s3_po_r;
  logic                     s3_last_r;

  always_comb begin
    s3_fg = cfg.couple ? sat_d(SUM_W'(ONE_Q) - SUM_W'(s2_ig_r)) : s2_fg_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_mf_r   <= s3_fg * s2_oc_r;
      s3_mi_r   <= s2_ig_r * s2_gg_r;
      s3_op_r   <= s2_op_r;
      s3_po_r   <= s2_po_r;
      s3_last_r <= s2_last_r;
    end
  end

  // Stage 4: new cell value, saturated.
  logic signed [DATA_W-1:0] s4_nc_r, s4_op_r, s4_po_r;
  logic                     s4_last_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_nc_r   <= sat_d(qround(s3_mf_r) + qround(s3_mi_r));
      s4_op_r   <= s3_op_r;
      s4_po_r   <= s3_po_r;
      s4_last_r <= s3_last_r;
    end
  end

  // Stage 5: output peephole product and the activation of the new cell.
  logic signed [PROD_W-1:0] s5_mo_r;
  logic signed [DATA_W-1:0] s5_ao_r, s5_op_r, s5_nc_r;
  logic                     s5_last_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_mo_r   <= s4_po_r * s4_nc_r;
      s5_ao_r   <= act(cfg.out_sel, s4_nc_r);
      s5_op_r   <= s4_op_r;
      s5_nc_r   <= s4_nc_r;
      s5_last_r <= s4_last_r;
    end
  end

  // Stage 6: output gate sum, clipping and activation.
  logic signed [DATA_W-1:0] s6_opk;
  logic signed [DATA_W-1:0] s6_og_r, s6_ao_r, s6_nc_r;
  logic                     s6_last_r;

  always_comb begin
    s6_opk = cfg.peep_en ? sat_d(SUM_W'(s5_op_r) + qround(s5_mo_r)) : s5_op_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s6_og_r   <= act(cfg.gate_sel, clipv(cfg.clip_en, cfg.clip_level, s6_opk));
      s6_ao_r   <= s5_ao_r;
      s6_nc_r   <= s5_nc_r;
      s6_last_r <= s5_last_r;
    end
  end

  // Stage 7: hidden product.
  logic signed [PROD_W-1:0] s7_mh_r;
  logic signed [DATA_W-1:0] s7_nc_r;
  logic                     s7_last_r;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s7_mh_r   <= s6_og_r * s6_ao_r;
      s7_nc_r   <= s6_nc_r;
      s7_last_r <= s6_last_r;
    end
  end

  // Stage 8: round and saturate the hidden value into the output register.
  out_item_t s8_out_r;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s8_out_r.new_cell   <= s7_nc_r;
      s8_out_r.new_hidden <= sat_d(qround(s7_mh_r));
      s8_out_r.last_out   <= s7_last_r;
    end
  end

  assign out_data = s8_out_r;

endmodule

`default_nettype wire

>>> sv/lstm_gate_cell_update_top.sv
// Top level of the LSTM gate and cell update block (one hidden unit per request).
// Depends on lgcu_pkg, lgcu_cfg and lgcu_dp.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one request per hidden
//   unit: four gate pre-activations, the old cell value and three peephole
//   weights, all signed Q3.12, plus a last-unit marker.
//   Output channel out_valid / out_stall / out_data returns the new cell and
//   hidden values and the copied marker, one result per request, in order.
//   A request is taken at a rising edge where valid is high and stall is low.
//   A request passes through the eight-stage datapath with its multipliers to
//   out_valid; throughput is one request per cycle while out_stall is low.
//   When the receiver stalls, stages fill up behind the output register; a
//   stage holds only while the one ahead of it is full, so bubbles collapse
//   and in_stall rises only once every stage holds a request.
//   The cfg_* port writes registers 0..6 (clip enable, clip level, coupling,
//   peephole enable, gate, candidate and output activation selects); write
//   them only while no request is in flight.
//   Synchronous reset empties the pipeline and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module lstm_gate_cell_update_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  lgcu_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output lgcu_pkg::out_item_t             out_data,
  input  wire logic                       cfg_we,
  input  wire logic [2:0]                 cfg_index,
  input  wire logic [lgcu_pkg::CFG_W-1:0] cfg_wdata
);
  import lgcu_pkg::*;

  cfg_t cfg;

  // Configuration registers.
  lgcu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Pipelined datapath.
  lgcu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
